### rtl/rbsi_pkg.sv
package rbsi_pkg;

  // Number formats.
  localparam int FRAC_BITS = 16;
  localparam int CRD_W     = 32;
  localparam int DIR_W     = 18;
  localparam int HALF_W    = 31;
  localparam int DIST_W    = 31;
  localparam int NRM_W     = 3;
  localparam int AXES      = 3;
  localparam int LANES     = 2 * AXES;

  // Slab numerator (bound - origin) and its magnitude.
  localparam int DIFF_W = CRD_W + 3;
  localparam int MAG_W  = CRD_W + 1;
  localparam int DVD_W  = MAG_W + FRAC_BITS;
  localparam int DMAG_W = DIR_W;

  // Quotient recurrence: 32 quotient bits, two per pipeline stage.
  localparam int Q_W        = 32;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;
  localparam int NX_W       = (DVD_W > Q_W + DMAG_W) ? DVD_W : Q_W + DMAG_W;

  // Hit point arithmetic.
  localparam int PROD_W = DMAG_W + DIST_W;
  localparam int OFF_W  = PROD_W - FRAC_BITS;
  localparam int SUM_W  = ((CRD_W > OFF_W + 1) ? CRD_W : OFF_W + 1) + 1;

  localparam logic [Q_W-1:0] TMAX_SAT   = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] HALF_RANGE = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0] EPS_LSB = 1;

  typedef enum logic [NRM_W-1:0] {
    NRM_NONE  = 3'd0,
    NRM_NEG_X = 3'd1,
    NRM_POS_X = 3'd2,
    NRM_NEG_Y = 3'd3,
    NRM_POS_Y = 3'd4,
    NRM_NEG_Z = 3'd5,
    NRM_POS_Z = 3'd6
  } nrm_t;

  localparam nrm_t ENTRY_FACE [AXES] = '{NRM_NEG_X, NRM_NEG_Y, NRM_NEG_Z};
  localparam nrm_t EXIT_FACE  [AXES] = '{NRM_POS_X, NRM_POS_Y, NRM_POS_Z};

  // Side data that rides along with the quotient recurrence.
  typedef struct packed {
    logic [AXES-1:0][CRD_W-1:0] org;
    logic [AXES-1:0][DIR_W-1:0] dir;
    logic [LANES-1:0]           neg;
    logic [LANES-1:0]           sat;
    logic [AXES-1:0]            dzero;
    logic                       cmiss;
    logic                       in_box;
  } carry_t;

  // Recurrence state: partial remainder, dividend/quotient word, divisor.
  typedef struct packed {
    logic [LANES-1:0][DMAG_W-1:0] p;
    logic [LANES-1:0][Q_W-1:0]    x;
    logic [AXES-1:0][DMAG_W-1:0]  d;
  } divw_t;

endpackage

### rtl/rbsi_in_if.sv
interface rbsi_in_if import rbsi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CRD_W-1:0]  origin_x;
  logic signed [CRD_W-1:0]  origin_y;
  logic signed [CRD_W-1:0]  origin_z;
  logic signed [DIR_W-1:0]  dir_x;
  logic signed [DIR_W-1:0]  dir_y;
  logic signed [DIR_W-1:0]  dir_z;
  logic signed [CRD_W-1:0]  center_x;
  logic signed [CRD_W-1:0]  center_y;
  logic signed [CRD_W-1:0]  center_z;
  logic        [HALF_W-1:0] half_x;
  logic        [HALF_W-1:0] half_y;
  logic        [HALF_W-1:0] half_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, half_x, half_y, half_z, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                center_x, center_y, center_z, half_x, half_y, half_z, output ready);
endinterface

### rtl/rbsi_out_if.sv
interface rbsi_out_if import rbsi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic        [DIST_W-1:0] distance;
  logic signed [CRD_W-1:0]  point_x;
  logic signed [CRD_W-1:0]  point_y;
  logic signed [CRD_W-1:0]  point_z;
  logic        [NRM_W-1:0]  normal_code;

  modport source (output valid, hit, distance, point_x, point_y, point_z, normal_code,
                  input ready);
  modport sink (input valid, hit, distance, point_x, point_y, point_z, normal_code,
                output ready);
endinterface

### rtl/rbsi_div_stage.sv
module rbsi_div_stage import rbsi_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  carry_t in_carry,
  input  divw_t  in_divw,
  output logic   out_valid,
  input  logic   out_ready,
  output carry_t out_carry,
  output divw_t  out_divw
);

  logic              valid_r;
  carry_t            carry_r;
  divw_t             divw_r;
  divw_t             divw_nxt;
  logic [DMAG_W:0]   trial;
  logic [DMAG_W-1:0] part;
  logic [Q_W-1:0]    word;

  // Restoring division steps on all six lanes; quotient bits shift in at the bottom.
  always_comb begin
    divw_nxt = in_divw;
    trial    = '0;
    part     = '0;
    word     = '0;
    for (int l = 0; l < LANES; l++) begin
      part = in_divw.p[l];
      word = in_divw.x[l];
      for (int s = 0; s < DIV_STEPS; s++) begin
        trial = {part, word[Q_W-1]};
        word  = {word[Q_W-2:0], 1'b0};
        if (trial >= {1'b0, in_divw.d[l/2]}) begin
          part    = DMAG_W'(trial - {1'b0, in_divw.d[l/2]});
          word[0] = 1'b1;
        end else begin
          part = trial[DMAG_W-1:0];
        end
      end
      divw_nxt.p[l] = part;
      divw_nxt.x[l] = word;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      carry_r <= in_carry;
      divw_r  <= divw_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_carry = carry_r;
  assign out_divw  = divw_r;

endmodule

### rtl/ray_box_slab_intersect_top.sv
// Ray against axis-aligned box slab test in signed fixed point. One ray/box pair
// is taken per cycle on in_ch when out_ch is not stalled; its result leaves on
// out_ch after one setup stage, 16 stages of the quotient recurrence (six slab
// quotients in parallel, two quotient bits per stage), then stages for slab
// ordering, entry/exit selection, the hit point multiply and the final add with
// saturation. Every stage holds its item while the one after it is full, so
// bubbles close up and nothing is dropped during a stall.
// cfg_wdata is written by cfg_we; set it only while no item is in flight.
module ray_box_slab_intersect_top import rbsi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rbsi_in_if.sink    in_ch,
  rbsi_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  logic cfg_inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_inside_r <= 1'b0;
    end else if (cfg_we) begin
      cfg_inside_r <= cfg_wdata;
    end
  end

  // ---------------- Setup stage ----------------
  logic signed [CRD_W-1:0]  o_in [AXES];
  logic signed [CRD_W-1:0]  c_in [AXES];
  logic signed [DIR_W-1:0]  d_in [AXES];
  logic        [HALF_W-1:0] h_in [AXES];
  logic signed [DIFF_W-1:0] num  [LANES];
  logic        [MAG_W-1:0]  nmag;
  logic        [NX_W-1:0]   dvd;
  logic        [DMAG_W-1:0] dmag [AXES];
  logic signed [CRD_W:0]    od;
  logic        [MAG_W-1:0]  omag;
  logic                     in_box;
  carry_t                   carry_a_nxt;
  divw_t                    divw_a_nxt;

  logic   v_a_r, rdy_a;
  carry_t carry_a_r;
  divw_t  divw_a_r;

  assign o_in[0] = in_ch.origin_x;
  assign o_in[1] = in_ch.origin_y;
  assign o_in[2] = in_ch.origin_z;
  assign c_in[0] = in_ch.center_x;
  assign c_in[1] = in_ch.center_y;
  assign c_in[2] = in_ch.center_z;
  assign d_in[0] = in_ch.dir_x;
  assign d_in[1] = in_ch.dir_y;
  assign d_in[2] = in_ch.dir_z;
  assign h_in[0] = in_ch.half_x;
  assign h_in[1] = in_ch.half_y;
  assign h_in[2] = in_ch.half_z;

  // Slab numerators, signs, saturation check and the containment tests.
  always_comb begin
    carry_a_nxt = '0;
    divw_a_nxt  = '0;
    nmag        = '0;
    dvd         = '0;
    od          = '0;
    omag        = '0;
    in_box      = cfg_inside_r;
    for (int i = 0; i < AXES; i++) begin
      num[2*i]   = DIFF_W'(c_in[i]) - DIFF_W'(h_in[i]) - DIFF_W'(o_in[i]);
      num[2*i+1] = DIFF_W'(c_in[i]) + DIFF_W'(h_in[i]) - DIFF_W'(o_in[i]);
      dmag[i]    = d_in[i][DIR_W-1] ? DMAG_W'(-d_in[i]) : DMAG_W'(d_in[i]);
      carry_a_nxt.org[i]   = o_in[i];
      carry_a_nxt.dir[i]   = d_in[i];
      carry_a_nxt.dzero[i] = (d_in[i] == '0);
      divw_a_nxt.d[i]      = dmag[i];
      // A zero direction only asks whether the origin lies within the slab.
      if (d_in[i] == '0 &&
          ((!num[2*i][DIFF_W-1] && num[2*i] != '0) || num[2*i+1][DIFF_W-1])) begin
        carry_a_nxt.cmiss = 1'b1;
      end
      od   = (CRD_W+1)'(o_in[i]) - (CRD_W+1)'(c_in[i]);
      omag = od[CRD_W] ? MAG_W'(-od) : MAG_W'(od);
      if (omag > MAG_W'(h_in[i]) + MAG_W'(1)) begin
        in_box = 1'b0;
      end
    end
    for (int l = 0; l < LANES; l++) begin
      nmag = num[l][DIFF_W-1] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
      dvd  = NX_W'({nmag, {FRAC_BITS{1'b0}}});
      carry_a_nxt.neg[l] = num[l][DIFF_W-1] != d_in[l/2][DIR_W-1];
      carry_a_nxt.sat[l] = (dvd >> Q_W) >= NX_W'(dmag[l/2]);
      divw_a_nxt.p[l]    = dvd[Q_W +: DMAG_W];
      divw_a_nxt.x[l]    = dvd[Q_W-1:0];
    end
    carry_a_nxt.in_box = in_box;
  end

  // ---------------- Quotient recurrence ----------------
  logic   dv   [DIV_STAGES+1];
  logic   drdy [DIV_STAGES+1];
  carry_t dc   [DIV_STAGES+1];
  divw_t  dw   [DIV_STAGES+1];
  logic   rdy_b;

  assign rdy_a       = !v_a_r || drdy[0];
  assign in_ch.ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (rdy_a) begin
      v_a_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_ch.valid) begin
      carry_a_r <= carry_a_nxt;
      divw_a_r  <= divw_a_nxt;
    end
  end

  assign dv[0] = v_a_r;
  assign dc[0] = carry_a_r;
  assign dw[0] = divw_a_r;
  assign drdy[DIV_STAGES] = rdy_b;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    rbsi_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv[k]),
      .in_ready  (drdy[k]),
      .in_carry  (dc[k]),
      .in_divw   (dw[k]),
      .out_valid (dv[k+1]),
      .out_ready (drdy[k+1]),
      .out_carry (dc[k+1]),
      .out_divw  (dw[k+1])
    );
  end

  // ---------------- Stage B: saturate quotients, order each slab ----------------
  logic [Q_W-1:0] tq [LANES];
  logic [Q_W-1:0] t1_nxt [AXES];
  logic [Q_W-1:0] t2_nxt [AXES];
  nrm_t           en_nxt [AXES];
  nrm_t           ex_nxt [AXES];

  logic           v_b_r, rdy_c;
  carry_t         carry_b_r;
  logic [Q_W-1:0] t1_b_r [AXES];
  logic [Q_W-1:0] t2_b_r [AXES];
  nrm_t           en_b_r [AXES];
  nrm_t           ex_b_r [AXES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (dc[DIV_STAGES].neg[l]) begin
        if (dc[DIV_STAGES].sat[l] || dw[DIV_STAGES].x[l] > HALF_RANGE) begin
          tq[l] = HALF_RANGE;
        end else begin
          tq[l] = Q_W'(-dw[DIV_STAGES].x[l]);
        end
      end else begin
        if (dc[DIV_STAGES].sat[l] || dw[DIV_STAGES].x[l] > TMAX_SAT) begin
          tq[l] = TMAX_SAT;
        end else begin
          tq[l] = dw[DIV_STAGES].x[l];
        end
      end
    end
    for (int i = 0; i < AXES; i++) begin
      if ($signed(tq[2*i]) > $signed(tq[2*i+1])) begin
        t1_nxt[i] = tq[2*i+1];
        t2_nxt[i] = tq[2*i];
        en_nxt[i] = EXIT_FACE[i];
        ex_nxt[i] = ENTRY_FACE[i];
      end else begin
        t1_nxt[i] = tq[2*i];
        t2_nxt[i] = tq[2*i+1];
        en_nxt[i] = ENTRY_FACE[i];
        ex_nxt[i] = EXIT_FACE[i];
      end
    end
  end

  assign rdy_b = !v_b_r || rdy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else if (rdy_b) begin
      v_b_r <= dv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && dv[DIV_STAGES]) begin
      carry_b_r <= dc[DIV_STAGES];
      t1_b_r    <= t1_nxt;
      t2_b_r    <= t2_nxt;
      en_b_r    <= en_nxt;
      ex_b_r    <= ex_nxt;
    end
  end

  // ---------------- Stage C: entry/exit tracking and distance choice ----------------
  logic signed [Q_W-1:0] tmin, tmax, dsel;
  nrm_t                  nin, nout, nsel;
  logic                  miss, hit_c;
  logic [DIST_W-1:0]     dist_c;
  nrm_t                  nrm_c;

  logic              v_c_r, rdy_d;
  logic              hit_c_r;
  logic [DIST_W-1:0] dist_c_r;
  nrm_t              nrm_c_r;
  logic [AXES-1:0][CRD_W-1:0] org_c_r;
  logic [AXES-1:0][DIR_W-1:0] dir_c_r;

  always_comb begin
    tmin = '0;
    tmax = TMAX_SAT;
    nin  = NRM_NONE;
    nout = NRM_NONE;
    miss = carry_b_r.cmiss;
    for (int i = 0; i < AXES; i++) begin
      if (!carry_b_r.dzero[i]) begin
        if ($signed(t1_b_r[i]) > tmin) begin
          tmin = t1_b_r[i];
          nin  = en_b_r[i];
        end
        if ($signed(t2_b_r[i]) < tmax) begin
          tmax = t2_b_r[i];
          nout = ex_b_r[i];
        end
        if (tmin > tmax) begin
          miss = 1'b1;
        end
      end
    end
    // Fall back to the exit when the entry is not ahead of the origin.
    dsel = tmin;
    nsel = nin;
    if (dsel <= EPS_LSB) begin
      dsel = tmax;
      nsel = nout;
    end
    hit_c  = !miss && (dsel > EPS_LSB);
    dist_c = dsel[DIST_W-1:0];
    nrm_c  = nsel;
    if (carry_b_r.in_box) begin
      hit_c  = 1'b1;
      dist_c = '0;
      nrm_c  = NRM_NONE;
    end else if (!hit_c) begin
      dist_c = '0;
      nrm_c  = NRM_NONE;
    end
  end

  assign rdy_c = !v_c_r || rdy_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (rdy_c) begin
      v_c_r <= v_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && v_b_r) begin
      hit_c_r  <= hit_c;
      dist_c_r <= dist_c;
      nrm_c_r  <= nrm_c;
      org_c_r  <= carry_b_r.org;
      dir_c_r  <= carry_b_r.dir;
    end
  end

  // ---------------- Stage D: direction times distance ----------------
  logic [DMAG_W-1:0] dm_d [AXES];
  logic [PROD_W-1:0] prod_nxt [AXES];

  logic              v_d_r, rdy_e;
  logic              hit_d_r;
  logic [DIST_W-1:0] dist_d_r;
  nrm_t              nrm_d_r;
  logic [AXES-1:0][CRD_W-1:0] org_d_r;
  logic [AXES-1:0]   dneg_d_r;
  logic [PROD_W-1:0] prod_d_r [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      dm_d[i] = dir_c_r[i][DIR_W-1] ? DMAG_W'(-dir_c_r[i]) : DMAG_W'(dir_c_r[i]);
      prod_nxt[i] = PROD_W'(dm_d[i]) * PROD_W'(dist_c_r);
    end
  end

  assign rdy_d = !v_d_r || rdy_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r <= 1'b0;
    end else if (rdy_d) begin
      v_d_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && v_c_r) begin
      hit_d_r  <= hit_c_r;
      dist_d_r <= dist_c_r;
      nrm_d_r  <= nrm_c_r;
      org_d_r  <= org_c_r;
      prod_d_r <= prod_nxt;
      for (int i = 0; i < AXES; i++) begin
        dneg_d_r[i] <= dir_c_r[i][DIR_W-1];
      end
    end
  end

  // ---------------- Stage E: hit point add, saturation, output register ----------------
  localparam logic signed [SUM_W-1:0] PT_MAX = SUM_W'(TMAX_SAT);
  localparam logic signed [SUM_W-1:0] PT_MIN = -PT_MAX - SUM_W'(1);

  logic        [OFF_W-1:0] off;
  logic signed [SUM_W-1:0] soff;
  logic signed [SUM_W-1:0] sum;
  logic        [CRD_W-1:0] pt_nxt [AXES];

  logic              v_e_r;
  logic              hit_e_r;
  logic [DIST_W-1:0] dist_e_r;
  nrm_t              nrm_e_r;
  logic [CRD_W-1:0]  pt_e_r [AXES];

  always_comb begin
    off  = '0;
    soff = '0;
    sum  = '0;
    for (int i = 0; i < AXES; i++) begin
      off  = prod_d_r[i][PROD_W-1:FRAC_BITS];
      soff = dneg_d_r[i] ? -SUM_W'(off) : SUM_W'(off);
      sum  = SUM_W'($signed(org_d_r[i])) + soff;
      if (!hit_d_r) begin
        pt_nxt[i] = '0;
      end else if (sum > PT_MAX) begin
        pt_nxt[i] = TMAX_SAT;
      end else if (sum < PT_MIN) begin
        pt_nxt[i] = HALF_RANGE;
      end else begin
        pt_nxt[i] = sum[CRD_W-1:0];
      end
    end
  end

  assign rdy_e = !v_e_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e_r <= 1'b0;
    end else if (rdy_e) begin
      v_e_r <= v_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e && v_d_r) begin
      hit_e_r  <= hit_d_r;
      dist_e_r <= dist_d_r;
      nrm_e_r  <= nrm_d_r;
      pt_e_r   <= pt_nxt;
    end
  end

  assign out_ch.valid       = v_e_r;
  assign out_ch.hit         = hit_e_r;
  assign out_ch.distance    = dist_e_r;
  assign out_ch.point_x     = pt_e_r[0];
  assign out_ch.point_y     = pt_e_r[1];
  assign out_ch.point_z     = pt_e_r[2];
  assign out_ch.normal_code = nrm_e_r;

endmodule

### tb/ray_box_slab_intersect_top_tb.sv
`timescale 1ns / 1ps

module ray_box_slab_intersect_top_tb;
  import rbsi_pkg::*;

  typedef struct packed {
    logic signed [CRD_W-1:0]  ox, oy, oz;
    logic signed [DIR_W-1:0]  dx, dy, dz;
    logic signed [CRD_W-1:0]  cx, cy, cz;
    logic        [HALF_W-1:0] hx, hy, hz;
  } ray_box_t;

  typedef struct packed {
    logic                     hit;
    logic        [DIST_W-1:0] distance;
    logic signed [CRD_W-1:0]  px, py, pz;
    logic        [NRM_W-1:0]  nrm;
  } hit_rec_t;

  // Expected hit records, in order, with their own copy of the mode bit.
  class hit_scoreboard;
    hit_rec_t pending[$];
    bit       zero_inside;
    int       mismatches;
    int       checked;

    static function longint slab_param(longint num, longint d);
      longint unsigned q;
      longint unsigned nm;
      longint unsigned dm;
      nm = num < 0 ? -num : num;
      dm = d < 0 ? -d : d;
      q = (nm << FRAC_BITS) / dm;
      if ((num < 0) != (d < 0)) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return -longint'(q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return longint'(q);
    endfunction

    function void note_input(ray_box_t r);
      longint o[3], d[3], c[3], h[3];
      longint tmin, tmax, tpar, lo, hi, t1, t2, tt, sum;
      longint unsigned p;
      logic [NRM_W-1:0] nin, nout, en, ex, tc, nrm;
      bit miss, in_box;
      hit_rec_t e;
      o = '{r.ox, r.oy, r.oz};
      d = '{r.dx, r.dy, r.dz};
      c = '{r.cx, r.cy, r.cz};
      h = '{r.hx, r.hy, r.hz};
      e = '0;
      tmin = 0;
      tmax = 64'h7FFF_FFFF;
      nin = NRM_NONE;
      nout = NRM_NONE;
      miss = 0;
      // Origin inside the box short-circuits the slab test in zero mode.
      if (zero_inside) begin
        in_box = 1;
        for (int i = 0; i < 3; i++) begin
          tt = o[i] - c[i];
          if (tt < 0) tt = -tt;
          if (tt > h[i] + 1) in_box = 0;
        end
        if (in_box) begin
          e.hit = 1;
          e.px = r.ox;
          e.py = r.oy;
          e.pz = r.oz;
          pending.push_back(e);
          return;
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (miss) break;
        lo = c[i] - h[i];
        hi = c[i] + h[i];
        en = ENTRY_FACE[i];
        ex = EXIT_FACE[i];
        if (d[i] == 0) begin
          if (o[i] < lo || o[i] > hi) miss = 1;
          continue;
        end
        t1 = slab_param(lo - o[i], d[i]);
        t2 = slab_param(hi - o[i], d[i]);
        if (t1 > t2) begin
          tt = t1; t1 = t2; t2 = tt;
          tc = en; en = ex; ex = tc;
        end
        if (t1 > tmin) begin
          tmin = t1;
          nin = en;
        end
        if (t2 < tmax) begin
          tmax = t2;
          nout = ex;
        end
        if (tmin > tmax) miss = 1;
      end
      tpar = tmin;
      nrm = nin;
      if (tpar <= 1) begin
        tpar = tmax;
        nrm = nout;
      end
      if (!miss && tpar > 1) begin
        e.hit = 1;
        e.distance = tpar[DIST_W-1:0];
        for (int i = 0; i < 3; i++) begin
          p = ((d[i] < 0 ? -d[i] : d[i]) * tpar) >> FRAC_BITS;
          sum = o[i] + (d[i] < 0 ? -longint'(p) : longint'(p));
          if (sum > 64'sd2147483647) sum = 64'sd2147483647;
          if (sum < -64'sd2147483648) sum = -64'sd2147483648;
          if (i == 0) e.px = sum[31:0];
          else if (i == 1) e.py = sum[31:0];
          else e.pz = sum[31:0];
        end
        e.nrm = nrm;
      end
      pending.push_back(e);
    endfunction

    function void check_result(hit_rec_t a);
      hit_rec_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", a);
        return;
      end
      e = pending.pop_front();
      if (a.hit !== e.hit || a.distance !== e.distance || a.px !== e.px ||
          a.py !== e.py || a.pz !== e.pz || a.nrm !== e.nrm) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: result %0d exp hit=%b d=%h p=%h/%h/%h n=%0d",
                    " got hit=%b d=%h p=%h/%h/%h n=%0d"},
                   checked, e.hit, e.distance, e.px, e.py, e.pz, e.nrm,
                   a.hit, a.distance, a.px, a.py, a.pz, a.nrm);
      end
    endfunction
  endclass

  localparam int LATENCY = 21;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_wdata = 0;

  rbsi_in_if  in_ch ();
  rbsi_out_if out_ch ();

  ray_box_slab_intersect_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  hit_scoreboard sb = new();
  longint cycles = 0;
  bit     calm_stretch = 0;
  bit     hold_sink = 0;
  int     sent = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.origin_x = 0; in_ch.origin_y = 0; in_ch.origin_z = 0;
    in_ch.dir_x = 0; in_ch.dir_y = 0; in_ch.dir_z = 0;
    in_ch.center_x = 0; in_ch.center_y = 0; in_ch.center_z = 0;
    in_ch.half_x = 0; in_ch.half_y = 0; in_ch.half_z = 0;
    out_ch.ready = 0;
  end

  // Cycle limit guards against a hung pipeline.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(negedge clk) begin
    if (!rst_n || hold_sink) out_ch.ready <= 0;
    else out_ch.ready <= calm_stretch || ($urandom_range(99) >= 8);
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.hit, out_ch.distance, out_ch.point_x, out_ch.point_y,
                        out_ch.point_z, out_ch.normal_code});
  end

  // Offers one item and waits for its transfer, with an optional idle gap first.
  // Valid stays high after the transfer so that items can follow back to back.
  task automatic send_ray(ray_box_t r);
    if (!calm_stretch) begin
      while ($urandom_range(99) < 8) begin
        in_ch.valid <= 0;
        @(negedge clk);
      end
    end
    in_ch.valid <= 1;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z, in_ch.dir_x, in_ch.dir_y,
     in_ch.dir_z, in_ch.center_x, in_ch.center_y, in_ch.center_z, in_ch.half_x,
     in_ch.half_y, in_ch.half_z} <= r;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(r);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_mode(bit v);
    drain_pipe();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.zero_inside = v;
  endtask

  function automatic logic signed [DIR_W-1:0] rand_dir();
    case ($urandom_range(5))
      0: return 0;
      1: return 18'sd65536;
      2: return -18'sd65536;
      3: return 18'($urandom);
      default: return $signed(18'($urandom_range(131072))) - 18'sd65536;
    endcase
  endfunction

  function automatic logic signed [CRD_W-1:0] rand_crd(bit wide);
    if (wide) return $urandom;
    return $signed(32'($urandom_range(32'h0040_0000))) - 32'sh0020_0000;
  endfunction

  // Mostly rays aimed near moderate boxes, some with full-range noise.
  function automatic ray_box_t rand_ray();
    ray_box_t r;
    bit wide;
    wide = $urandom_range(9) == 0;
    r.ox = rand_crd(wide); r.oy = rand_crd(wide); r.oz = rand_crd(wide);
    r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
    r.cx = rand_crd(wide); r.cy = rand_crd(wide); r.cz = rand_crd(wide);
    if (wide) begin
      r.hx = 31'($urandom); r.hy = 31'($urandom); r.hz = 31'($urandom);
    end else begin
      r.hx = 31'($urandom_range(32'h0020_0000));
      r.hy = 31'($urandom_range(32'h0020_0000));
      r.hz = 31'($urandom_range(32'h0020_0000));
    end
    if ($urandom_range(3) == 0) begin
      r.ox = r.cx + $signed(32'($urandom_range(16))) - 8;
      r.oy = r.cy;
      r.oz = r.cz;
    end
    return r;
  endfunction

  task automatic directed_rays();
    ray_box_t r;
    // Straight-on hit along +x, then along -y and +z.
    r = '{-32'sh50000, 0, 0, 18'sd65536, 0, 0, 0, 0, 0, 31'h10000, 31'h10000, 31'h10000};
    send_ray(r);
    r = '{0, 32'sh50000, 0, 0, -18'sd65536, 0, 0, 0, 0, 31'h10000, 31'h10000, 31'h10000};
    send_ray(r);
    r = '{0, 0, -32'sh50000, 0, 0, 18'sd65536, 0, 0, 0, 31'h10000, 31'h20000, 31'h10000};
    send_ray(r);
    // Zero direction axis outside its slab misses.
    r = '{-32'sh50000, 32'sh50000, 0, 18'sd65536, 0, 0, 0, 0, 0, 31'h10000, 31'h10000,
          31'h10000};
    send_ray(r);
    // All directions zero, origin inside the box.
    r = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 31'h10000, 31'h10000, 31'h10000};
    send_ray(r);
    // Origin inside: exit face taken unless the inside-box mode is set.
    r = '{0, 0, 0, 18'sd46341, 18'sd46341, 0, 0, 0, 0, 31'h10000, 31'h10000, 31'h10000};
    send_ray(r);
    // Box behind the origin misses.
    r = '{32'sh50000, 0, 0, 18'sd65536, 0, 0, 0, 0, 0, 31'h10000, 31'h10000, 31'h10000};
    send_ray(r);
    // Tiny direction saturates the quotient; extreme coordinates and halves.
    r = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 18'sd1, -18'sd1, -18'sh20000,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
          31'h7FFF_FFFF};
    send_ray(r);
    r = '{32'sh7FFF_FFFF, 0, 0, -18'sd65536, 18'sd1, 0, 32'sh8000_0000, 0, 0,
          31'h7FFF_FFFF, 31'h0, 31'h0};
    send_ray(r);
    // Zero-size box, edge ties, and an origin just outside the face by one.
    r = '{-32'sh20000, 0, 0, 18'sd65536, 0, 0, 0, 0, 0, 0, 0, 0};
    send_ray(r);
    r = '{-32'sh10001, 32'sh10000, 0, 18'sd65536, 0, 0, 0, 0, 0, 31'h10000, 31'h10000,
          31'h10000};
    send_ray(r);
    r = '{-32'sh10001, 0, 0, 18'sd65536, 0, 0, 0, 0, 0, 31'h10000, 31'h10000, 31'h10000};
    send_ray(r);
    // Direction beyond unit magnitude and the most negative code.
    r = '{-32'sh80000, -32'sh80000, -32'sh80000, 18'sh1FFFF, 18'sh1FFFF, 18'sh20000,
          0, 0, 0, 31'h20000, 31'h20000, 31'h20000};
    send_ray(r);
    in_ch.valid <= 0;
  endtask

  task automatic random_rays(int n);
    for (int i = 0; i < n; i++) send_ray(rand_ray());
    in_ch.valid <= 0;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    directed_rays();
    set_mode(1);
    directed_rays();
    random_rays(100);

    // Long receiver hold-off while the sender keeps offering items.
    set_mode(0);
    fork
      begin
        hold_sink = 1;
        repeat (200) @(negedge clk);
        hold_sink = 0;
      end
      random_rays(60);
    join

    // Sender pauses until every result is back, then a stretch with no idling.
    drain_pipe();
    calm_stretch = 1;
    random_rays(80);
    calm_stretch = 0;
    set_mode(1);
    random_rays(120);
    set_mode(0);
    random_rays(60);

    drain_pipe();
    $display("Sent %0d ray/box items over both inside-box modes, %0d results checked.",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d left over", sb.mismatches, sb.pending.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### files.f
rtl/rbsi_pkg.sv
rtl/rbsi_in_if.sv
rtl/rbsi_out_if.sv
rtl/rbsi_div_stage.sv
rtl/ray_box_slab_intersect_top.sv
tb/ray_box_slab_intersect_top_tb.sv
